// File: hdl/clga_pkg.sv
// shared types, constants and tables of the cyrillic lcd glyph allocator
package clga_pkg;

   localparam int USER_SLOTS_DEF = 8;
   localparam int ROWS_PER_GLYPH = 8;
   localparam int ROW_W          = $clog2(ROWS_PER_GLYPH);
   localparam int FONT_GLYPHS    = 20;

   localparam logic [7:0] SUBST_RESET = 8'h3F;
   localparam logic [2:0] CYR_PREFIX  = 3'b100;
   localparam logic [7:0] LAST_GLYPH  = 8'h13;

   typedef enum logic [1:0] {
      KIND_CODE = 2'd0,
      KIND_ROW  = 2'd1,
      KIND_ADDR = 2'd2
   } clga_kind_type;

   typedef struct packed {
      logic take_char;
      logic take_eof;
      logic load_row;
   } clga_cmd_type;

   typedef struct packed {
      logic used_zero;
      logic dump_last;
      logic out_free;
   } clga_status_type;

   localparam logic [7:0] RECODE_TABLE [32] = '{
      8'h41, 8'h00, 8'h42, 8'h01, 8'h02, 8'h45, 8'h03, 8'h04,
      8'h05, 8'h06, 8'h4b, 8'h07, 8'h4d, 8'h48, 8'h4f, 8'h08,
      8'h50, 8'h43, 8'h54, 8'h09, 8'h0a, 8'h58, 8'h0b, 8'h0c,
      8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h62, 8'h11, 8'h12, 8'h13
   };

   localparam logic [4:0] FONT_ROM [FONT_GLYPHS][ROWS_PER_GLYPH] = '{
      '{5'h1F,5'h11,5'h10,5'h1E,5'h11,5'h11,5'h1E,5'h00},
      '{5'h1F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h00},
      '{5'h0F,5'h05,5'h05,5'h09,5'h11,5'h1F,5'h11,5'h11},
      '{5'h15,5'h15,5'h15,5'h0E,5'h15,5'h15,5'h15,5'h00},
      '{5'h1E,5'h01,5'h01,5'h06,5'h01,5'h01,5'h1E,5'h00},
      '{5'h11,5'h11,5'h13,5'h15,5'h19,5'h11,5'h11,5'h00},
      '{5'h04,5'h15,5'h11,5'h13,5'h15,5'h19,5'h11,5'h00},
      '{5'h0F,5'h05,5'h05,5'h05,5'h05,5'h15,5'h09,5'h00},
      '{5'h1F,5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h00},
      '{5'h11,5'h11,5'h11,5'h0A,5'h04,5'h08,5'h10,5'h00},
      '{5'h0E,5'h15,5'h15,5'h15,5'h0E,5'h04,5'h04,5'h00},
      '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1F,5'h01},
      '{5'h11,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h01,5'h00},
      '{5'h15,5'h15,5'h15,5'h15,5'h15,5'h15,5'h1F,5'h00},
      '{5'h15,5'h15,5'h15,5'h15,5'h15,5'h15,5'h1F,5'h01},
      '{5'h18,5'h08,5'h08,5'h0E,5'h09,5'h09,5'h0E,5'h00},
      '{5'h11,5'h11,5'h11,5'h19,5'h15,5'h15,5'h19,5'h00},
      '{5'h0E,5'h11,5'h05,5'h0B,5'h01,5'h11,5'h0E,5'h00},
      '{5'h12,5'h15,5'h15,5'h1D,5'h15,5'h15,5'h12,5'h00},
      '{5'h0F,5'h11,5'h11,5'h0F,5'h05,5'h09,5'h11,5'h00}
   };

   function automatic logic [4:0] font_row(input logic [4:0] glyph,
                                           input logic [ROW_W-1:0] row);
      logic [4:0] bits;
      bits = 5'd0;
      if (int'(glyph) < FONT_GLYPHS) begin
         bits = FONT_ROM[glyph][row];
      end
      return bits;
   endfunction

endpackage

// File: hdl/clga_if.sv
// valid/ready channel interfaces for character items and result items
interface clga_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] char_code;
   logic       row_begin;

   modport source (output valid, mode, char_code, row_begin, input ready);
   modport sink   (input valid, mode, char_code, row_begin, output ready);
endinterface

interface clga_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data;
   logic       row_mark;
   logic       glyph_start;
   logic       last;

   modport source (output valid, kind, data, row_mark, glyph_start, last, input ready);
   modport sink   (input valid, kind, data, row_mark, glyph_start, last, output ready);
endinterface

// File: hdl/clga_ctrl.sv
// controller state machine: character pass and end-of-frame glyph dump
module clga_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_mode,
   output logic                       req_ready,
   input  clga_pkg::clga_status_type  status,
   output clga_pkg::clga_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_RUN  = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      take;

   assign req_ready = (state_ff == ST_RUN) && status.out_free;
   assign take      = req_valid && req_ready;

   always_comb begin
      cmd.take_char = take && !req_mode;
      cmd.take_eof  = take && req_mode;
      cmd.load_row  = (state_ff == ST_DUMP) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd.take_eof && !status.used_zero) begin
               state_in = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (cmd.load_row && status.dump_last) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/clga_dpath.sv
// datapath: recoding, slot store and compare, glyph row counters, output register
module clga_dpath #(
   parameter int USER_SLOTS = clga_pkg::USER_SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [7:0]                 csr_wr_data,
   input  logic [7:0]                 req_char_code,
   input  logic                       req_row_begin,
   input  clga_pkg::clga_cmd_type     cmd,
   output clga_pkg::clga_status_type  status,
   clga_rsp_if.source                 rsp
);

   localparam int USED_W = $clog2(USER_SLOTS + 1);
   localparam int IDX_W  = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
   localparam int ROW_W  = clga_pkg::ROW_W;

   logic [4:0]        slot_glyph_ff [USER_SLOTS];
   logic [USED_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [7:0]        subst_ff;

   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff;
   logic [7:0]        data_ff;
   logic              mark_ff, start_ff, last_ff;

   logic [7:0]        glyph_code;
   logic              cyr, lookalike, hit_any, alloc;
   logic [IDX_W-1:0]  hit_idx;
   logic [7:0]        char_data;
   logic [4:0]        dump_glyph;

   assign status.out_free  = !valid_ff || rsp.ready;
   assign status.used_zero = (used_ff == '0);
   assign status.dump_last = ((USED_W'(idx_ff) + USED_W'(1)) == used_ff)
                             && (row_ff == ROW_W'(clga_pkg::ROWS_PER_GLYPH - 1));

   // character mapping
   always_comb begin
      glyph_code = clga_pkg::RECODE_TABLE[req_char_code[4:0]];
      cyr        = (req_char_code[7:5] == clga_pkg::CYR_PREFIX);
      lookalike  = (glyph_code > clga_pkg::LAST_GLYPH);
      hit_any    = 1'b0;
      hit_idx    = '0;
      for (int i = USER_SLOTS - 1; i >= 0; i--) begin
         if ((USED_W'(i) < used_ff) && (slot_glyph_ff[i] == glyph_code[4:0])) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
      alloc = 1'b0;
      priority if (!cyr) begin
         char_data = req_char_code;
      end else if (lookalike) begin
         char_data = glyph_code;
      end else if (hit_any) begin
         char_data = 8'(hit_idx);
      end else if (used_ff >= USED_W'(USER_SLOTS)) begin
         char_data = subst_ff;
      end else begin
         char_data = 8'(used_ff);
         alloc     = 1'b1;
      end
   end

   assign dump_glyph = slot_glyph_ff[idx_ff];

   always_comb begin
      used_in = used_ff;
      idx_in  = idx_ff;
      row_in  = row_ff;
      if (cmd.take_char && alloc) begin
         used_in = used_ff + USED_W'(1);
      end
      if (cmd.take_eof) begin
         idx_in = '0;
         row_in = '0;
      end
      if (cmd.load_row) begin
         row_in = row_ff + ROW_W'(1);
         if (row_ff == ROW_W'(clga_pkg::ROWS_PER_GLYPH - 1)) begin
            idx_in = idx_ff + IDX_W'(1);
         end
         if (status.dump_last) begin
            used_in = '0;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.take_char || (cmd.take_eof && status.used_zero) || cmd.load_row) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         idx_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
         subst_ff <= clga_pkg::SUBST_RESET;
      end else begin
         used_ff  <= used_in;
         idx_ff   <= idx_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            subst_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_char && alloc) begin
         slot_glyph_ff[used_ff[IDX_W-1:0]] <= glyph_code[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_char) begin
         kind_ff  <= clga_pkg::KIND_CODE;
         data_ff  <= char_data;
         mark_ff  <= req_row_begin;
         start_ff <= 1'b0;
         last_ff  <= 1'b1;
      end else if (cmd.take_eof && status.used_zero) begin
         kind_ff  <= clga_pkg::KIND_ADDR;
         data_ff  <= 8'd0;
         mark_ff  <= 1'b0;
         start_ff <= 1'b1;
         last_ff  <= 1'b1;
      end else if (cmd.load_row) begin
         kind_ff  <= clga_pkg::KIND_ROW;
         data_ff  <= {3'b000, clga_pkg::font_row(dump_glyph, row_ff)};
         mark_ff  <= 1'b0;
         start_ff <= (idx_ff == '0) && (row_ff == '0);
         last_ff  <= status.dump_last;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.data        = data_ff;
   assign rsp.row_mark    = mark_ff;
   assign rsp.glyph_start = start_ff;
   assign rsp.last        = last_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(USER_SLOTS))
      else $error("slot count beyond slot store");

   a_dump_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_row && status.dump_last) |=> (used_ff == '0))
      else $error("slots not freed after glyph dump");

   a_addr_alone_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (kind_ff == clga_pkg::KIND_ADDR)) |-> (last_ff && start_ff))
      else $error("address command item not marked first and last");

   a_no_take_in_dump: assert property (@(posedge clock) disable iff (reset)
      cmd.load_row |-> !(cmd.take_char || cmd.take_eof))
      else $error("item taken during glyph dump");
`endif

endmodule

// File: hdl/cyrillic_lcd_glyph_allocator.sv
// top level of the cyrillic lcd glyph allocator
//
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    mode, char_code, row_begin
//  rsp_chan  out  valid/ready    kind, data, row_mark, glyph_start, last
//  csr       in   csr_wr_en      csr_wr_data (substitute code)
//
// a character item's result is registered and shows on rsp_chan in the cycle after it is taken
// end of frame gives one item per cycle unless output stalls: 8 row bytes per allocated slot
// from the font rom (one address item if no slot is used); no item is taken while the glyph dump runs
// a stalled result holds in the output register; a new item is taken if it drains that cycle
// synchronous reset frees all slots and sets the substitute code to '?'
module cyrillic_lcd_glyph_allocator #(
   parameter int USER_SLOTS = clga_pkg::USER_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   clga_req_if.sink   req_chan,
   clga_rsp_if.source rsp_chan
);

   clga_pkg::clga_cmd_type    cmd;
   clga_pkg::clga_status_type status;
   logic                      ready;

   assign req_chan.ready = ready;

   clga_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   clga_dpath #(
      .USER_SLOTS (USER_SLOTS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_char_code (req_chan.char_code),
      .req_row_begin (req_chan.row_begin),
      .cmd           (cmd),
      .status        (status),
      .rsp           (rsp_chan)
   );

endmodule

// File: tb/tb_cyrillic_lcd_glyph_allocator.sv
// testbench of the cyrillic lcd glyph allocator: directed table, then random frames checked item by item
module tb_cyrillic_lcd_glyph_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         NUM_SLOTS    = 8;
   localparam int         GLYPH_LINES  = 8;
   localparam logic [7:0] CYR_LOW      = 8'h80;
   localparam logic [7:0] CYR_HIGH     = 8'hA0;
   localparam logic [7:0] MAX_GLYPH    = 8'h13;
   localparam logic [7:0] QMARK        = 8'h3F;
   localparam int         PHASES       = 4;
   localparam int         PHASE_ITEMS  = 50;
   localparam int         LONG_HOLD    = 300;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         CYCLE_LIMIT  = 2000000;

   localparam logic [7:0] CYR_RECODE [32] = '{
      8'h41, 8'h00, 8'h42, 8'h01, 8'h02, 8'h45, 8'h03, 8'h04,
      8'h05, 8'h06, 8'h4b, 8'h07, 8'h4d, 8'h48, 8'h4f, 8'h08,
      8'h50, 8'h43, 8'h54, 8'h09, 8'h0a, 8'h58, 8'h0b, 8'h0c,
      8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h62, 8'h11, 8'h12, 8'h13
   };

   localparam logic [4:0] GLYPH_BITMAP [20][8] = '{
      '{5'h1F,5'h11,5'h10,5'h1E,5'h11,5'h11,5'h1E,5'h00},
      '{5'h1F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h00},
      '{5'h0F,5'h05,5'h05,5'h09,5'h11,5'h1F,5'h11,5'h11},
      '{5'h15,5'h15,5'h15,5'h0E,5'h15,5'h15,5'h15,5'h00},
      '{5'h1E,5'h01,5'h01,5'h06,5'h01,5'h01,5'h1E,5'h00},
      '{5'h11,5'h11,5'h13,5'h15,5'h19,5'h11,5'h11,5'h00},
      '{5'h04,5'h15,5'h11,5'h13,5'h15,5'h19,5'h11,5'h00},
      '{5'h0F,5'h05,5'h05,5'h05,5'h05,5'h15,5'h09,5'h00},
      '{5'h1F,5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h00},
      '{5'h11,5'h11,5'h11,5'h0A,5'h04,5'h08,5'h10,5'h00},
      '{5'h0E,5'h15,5'h15,5'h15,5'h0E,5'h04,5'h04,5'h00},
      '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1F,5'h01},
      '{5'h11,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h01,5'h00},
      '{5'h15,5'h15,5'h15,5'h15,5'h15,5'h15,5'h1F,5'h00},
      '{5'h15,5'h15,5'h15,5'h15,5'h15,5'h15,5'h1F,5'h01},
      '{5'h18,5'h08,5'h08,5'h0E,5'h09,5'h09,5'h0E,5'h00},
      '{5'h11,5'h11,5'h11,5'h19,5'h15,5'h15,5'h19,5'h00},
      '{5'h0E,5'h11,5'h05,5'h0B,5'h01,5'h11,5'h0E,5'h00},
      '{5'h12,5'h15,5'h15,5'h1D,5'h15,5'h15,5'h12,5'h00},
      '{5'h0F,5'h11,5'h11,5'h0F,5'h05,5'h09,5'h11,5'h00}
   };

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       row_mark;
      logic       glyph_start;
      logic       last;
   } lcd_out_type;

   typedef struct packed {
      logic                    eof;
      logic [7:0]              code;
      logic                    rb;
      logic                    typed;
      clga_pkg::clga_kind_type kind;
      logic [7:0]              data;
   } directed_row_type;

   localparam directed_row_type DIRECTED [22] = '{
      '{1'b1, 8'hFF, 1'b1, 1'b1, clga_pkg::KIND_ADDR, 8'h00},
      '{1'b0, 8'h00, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h00},
      '{1'b0, 8'hFF, 1'b1, 1'b1, clga_pkg::KIND_CODE, 8'hFF},
      '{1'b0, 8'h7F, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h7F},
      '{1'b0, 8'hA0, 1'b1, 1'b1, clga_pkg::KIND_CODE, 8'hA0},
      '{1'b0, 8'h80, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h41},
      '{1'b0, 8'h81, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h00},
      '{1'b0, 8'h81, 1'b1, 1'b1, clga_pkg::KIND_CODE, 8'h00},
      '{1'b0, 8'h9F, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h01},
      '{1'b0, 8'h83, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h02},
      '{1'b0, 8'h84, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h03},
      '{1'b0, 8'h86, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h04},
      '{1'b0, 8'h87, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h05},
      '{1'b0, 8'h88, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h06},
      '{1'b0, 8'h89, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h07},
      '{1'b0, 8'h8B, 1'b1, 1'b1, clga_pkg::KIND_CODE, QMARK},
      '{1'b0, 8'h84, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h03},
      '{1'b0, 8'h9C, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h62},
      '{1'b1, 8'h00, 1'b0, 1'b0, clga_pkg::KIND_ROW,  8'h00},
      '{1'b1, 8'h00, 1'b1, 1'b1, clga_pkg::KIND_ADDR, 8'h00},
      '{1'b0, 8'h9F, 1'b0, 1'b1, clga_pkg::KIND_CODE, 8'h00},
      '{1'b1, 8'h55, 1'b1, 1'b0, clga_pkg::KIND_ROW,  8'h00}
   };

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   clga_req_if req_bus ();
   clga_rsp_if rsp_bus ();

   logic [7:0]  substitute_byte;
   logic [4:0]  glyph_in_slot [NUM_SLOTS];
   int          slot_count;
   lcd_out_type lcd_stream_q [$];
   int          mismatches;
   bit          tx_calm;
   bit          rx_calm;
   bit          hold_rsp;

   cyrillic_lcd_glyph_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [7:0] recode_char(input logic [7:0] code);
      logic [7:0] g;
      if (code < CYR_LOW || code >= CYR_HIGH) begin
         return code;
      end
      g = CYR_RECODE[code[4:0]];
      if (g > MAX_GLYPH) begin
         return g;
      end
      for (int i = 0; i < slot_count; i++) begin
         if (glyph_in_slot[i] == g[4:0]) begin
            return 8'(i);
         end
      end
      if (slot_count >= NUM_SLOTS) begin
         return substitute_byte;
      end
      glyph_in_slot[slot_count] = g[4:0];
      slot_count++;
      return 8'(slot_count - 1);
   endfunction

   task automatic recode_item(input logic eof, input logic [7:0] code, input logic rb);
      if (!eof) begin
         lcd_stream_q.push_back(lcd_out_type'{clga_pkg::KIND_CODE, recode_char(code), rb,
                                              1'b0, 1'b1});
      end else if (slot_count == 0) begin
         lcd_stream_q.push_back(lcd_out_type'{clga_pkg::KIND_ADDR, 8'h00, 1'b0, 1'b1, 1'b1});
      end else begin
         for (int k = 0; k < slot_count; k++) begin
            for (int r = 0; r < GLYPH_LINES; r++) begin
               lcd_stream_q.push_back(lcd_out_type'{clga_pkg::KIND_ROW,
                  {3'b000, GLYPH_BITMAP[glyph_in_slot[k]][r]}, 1'b0,
                  (k == 0 && r == 0), (k == slot_count - 1 && r == GLYPH_LINES - 1)});
            end
         end
         slot_count = 0;
      end
   endtask

   task automatic offer_item(input logic eof, input logic [7:0] code, input logic rb,
                             input logic typed, input lcd_out_type typed_out);
      int gap;
      int n0;
      if ($urandom_range(0, 15) == 0) begin
         tx_calm = !tx_calm;
      end
      gap = tx_calm ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.mode      = eof;
      req_bus.char_code = code;
      req_bus.row_begin = rb;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      n0 = lcd_stream_q.size();
      recode_item(eof, code, rb);
      if (typed) begin
         while (lcd_stream_q.size() > n0) begin
            void'(lcd_stream_q.pop_back());
         end
         lcd_stream_q.push_back(typed_out);
      end
   endtask

   task automatic park_sender();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic write_substitute(input logic [7:0] value);
      while (lcd_stream_q.size() != 0) @(posedge clock);
      repeat (2) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en       = 1'b0;
      substitute_byte = value;
   endtask

   initial begin
      int               n_sent;
      int               frame_len;
      logic [7:0]       c;
      directed_row_type row;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = 8'h00;
      req_bus.valid     = 1'b0;
      req_bus.mode      = 1'b0;
      req_bus.char_code = 8'h00;
      req_bus.row_begin = 1'b0;
      substitute_byte   = QMARK;
      slot_count        = 0;
      mismatches        = 0;
      tx_calm           = 1'b0;
      hold_rsp          = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         offer_item(row.eof, row.code, row.rb, row.typed,
                    lcd_out_type'{row.kind, row.data, row.eof ? 1'b0 : row.rb, row.eof, 1'b1});
      end

      for (int p = 0; p < PHASES; p++) begin
         park_sender();
         write_substitute(p == 0 ? 8'h00 : p == 1 ? 8'hFF : 8'($urandom));
         if (p == 1) begin
            // stall the result side while items keep coming
            hold_rsp = 1'b1;
            tx_calm  = 1'b1;
         end
         n_sent = 0;
         while (n_sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               frame_len = $urandom_range(1, 24);
               repeat (frame_len) begin
                  c = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32'h80, 32'h9F))
                                                 : 8'($urandom);
                  offer_item(1'b0, c, 1'($urandom), 1'b0, '0);
               end
               offer_item(1'b1, 8'($urandom), 1'($urandom), 1'b0, '0);
               n_sent += frame_len + 1;
            end else begin
               offer_item(1'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
               n_sent++;
            end
         end
      end

      park_sender();
      while (lcd_stream_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && lcd_stream_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      int          gap;
      lcd_out_type seen;
      lcd_out_type want;
      rsp_bus.ready = 1'b0;
      rx_calm       = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready = 1'b0;
            for (int h = 0; h < LONG_HOLD; h++) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if ($urandom_range(0, 15) == 0) begin
            rx_calm = !rx_calm;
         end
         gap = rx_calm ? 0 : $urandom_range(0, 11);
         if (gap != 0) begin
            rsp_bus.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         seen = {rsp_bus.kind, rsp_bus.data, rsp_bus.row_mark, rsp_bus.glyph_start,
                 rsp_bus.last};
         if (lcd_stream_q.size() == 0) begin
            mismatches++;
            $display("%0t: expected no item, got kind %0d data %h mark %b start %b last %b",
                     $time, seen.kind, seen.data, seen.row_mark, seen.glyph_start, seen.last);
         end else begin
            want = lcd_stream_q.pop_front();
            if (seen !== want) begin
               mismatches++;
               $display("%0t: expected kind %0d data %h mark %b start %b last %b",
                        $time, want.kind, want.data, want.row_mark, want.glyph_start,
                        want.last);
               $display("%0t:      got kind %0d data %h mark %b start %b last %b",
                        $time, seen.kind, seen.data, seen.row_mark, seen.glyph_start,
                        seen.last);
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
hdl/clga_pkg.sv
hdl/clga_if.sv
hdl/clga_ctrl.sv
hdl/clga_dpath.sv
hdl/cyrillic_lcd_glyph_allocator.sv
tb/tb_cyrillic_lcd_glyph_allocator.sv
